// ===== hw/rtl/wlr_pkg.sv =====
package wlr_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;
  localparam int WIDTH_BITS   = 16;

  localparam int VW = $clog2(MAX_VERTICES);      // vertex number bits
  localparam int EW = $clog2(MAX_EDGES);         // edge index bits
  localparam int LW = EW + 2;                    // link value bits (held plus one)
  localparam int CW = $clog2(MAX_VERTICES + 1);  // count bits
  localparam int NW = EW + 1;                    // edges stored count bits

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_ADD_RD,
    S_ADD_WR,
    S_Q_CLR,
    S_Q_POP,
    S_Q_HEAD,
    S_Q_FETCH,
    S_Q_LINK,
    S_Q_EDGE,
    S_Q_VIS,
    S_Q_DST,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/width_limited_reachability.sv =====
// channel | dir | ports                                      | handshake
// in      | in  | in_action in_vertex_a in_vertex_b in_width_value | in_valid/in_ready
// out     | out | out_reachable out_status                   | out_valid/out_ready
// cfg     | in  | cfg_vertex_count                           | cfg_we, no wait
// One word at a time. Clear sweeps the head store; add reads and then writes the heads of both ends.
// Query clears the visited store, then for each queued vertex reads the queue, head, link and edge
// memories, whose reads are registered, and follows each link before taking the next vertex.
// Reset is synchronous; after it the head store is swept, and no input is taken meanwhile.
// The result sits in an output register; the next word is taken once it is.
module width_limited_reachability
  import wlr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_vertex_a,
  input  logic [7:0]            in_vertex_b,
  input  logic [WIDTH_BITS-1:0] in_width_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_reachable,
  output logic [1:0]            out_status,
  input  logic                  cfg_we,
  input  logic [8:0]            cfg_vertex_count
);

  logic [VW-1:0]         mem_ea [MAX_EDGES];
  logic [VW-1:0]         mem_eb [MAX_EDGES];
  logic [WIDTH_BITS-1:0] mem_ew [MAX_EDGES];
  logic [LW-1:0]         mem_first [MAX_VERTICES];
  logic [LW-1:0]         mem_next [2*MAX_EDGES];
  logic                  mem_vis [MAX_VERTICES];
  logic [VW-1:0]         mem_q [MAX_VERTICES];

  state_t state_r, state_nxt;
  logic [8:0]            vcount_r;
  logic [NW-1:0]         nedge_r;
  logic [CW-1:0]         cnt_r;        // sweep index / queue head
  logic [CW-1:0]         tail_r;
  logic [VW-1:0]         va_r, vb_r;
  logic [WIDTH_BITS-1:0] w_r;
  logic [LW-1:0]         link_r;
  logic [LW-1:0]         fa_r;         // new head of va during add
  logic [VW-1:0]         other_r;
  logic                  wide_r;
  logic                  ovld_r, oreach_r;
  logic [1:0]            ostat_r;
  logic                  init_r;

  // read data registers
  logic [LW-1:0]         first_rd;
  logic [LW-1:0]         next_rd;
  logic [VW-1:0]         ea_rd, eb_rd;
  logic [WIDTH_BITS-1:0] ew_rd;
  logic                  vis_rd;
  logic [VW-1:0]         q_rd;

  logic [CW-1:0] lim;
  logic          range_bad;
  logic [LW-2:0] h;
  logic [EW-1:0] e;

  // edge endpoint and width check for the link in flight (data valid in S_Q_EDGE)
  logic [VW-1:0] other_sel;
  logic          link_ok;
  logic          visit_ok;

  assign lim = (vcount_r > 9'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_r);
  assign range_bad = ({1'b0, in_vertex_a} >= lim) || ({1'b0, in_vertex_b} >= lim);
  assign h = (LW-1)'(link_r - LW'(1));
  assign e = h[LW-2:1];

  assign link_ok   = {1'b0, e} < nedge_r;
  assign other_sel = h[0] ? ea_rd : eb_rd;
  // vis_rd read in S_Q_EDGE at other_sel; each S_Q_VIS writes before the next read
  assign visit_ok  = wide_r && !vis_rd && (tail_r < CW'(MAX_VERTICES));

  assign in_ready      = (state_r == S_IDLE) && !ovld_r && !init_r;
  assign out_valid     = ovld_r;
  assign out_reachable = oreach_r;
  assign out_status    = ostat_r;

  // second link of a self-loop chains to the first one, written in S_ADD_RD
  function automatic logic [LW-1:0] fa_sel(input logic [VW-1:0] a, input logic [VW-1:0] b);
    fa_sel = (a == b) ? fa_r : first_rd;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (init_r) state_nxt = S_CLR;
        else if (in_valid && in_ready) begin
          case (in_action)
            ACT_CLEAR: state_nxt = S_CLR;
            ACT_ADD:   state_nxt = (range_bad || nedge_r >= NW'(MAX_EDGES)) ? S_DONE
                                 : S_ADD_RD;
            ACT_QUERY: state_nxt = range_bad ? S_DONE : S_Q_CLR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR:     if (cnt_r == CW'(MAX_VERTICES - 1)) state_nxt = init_r ? S_IDLE : S_DONE;
      S_ADD_RD:  state_nxt = S_ADD_WR;
      S_ADD_WR:  state_nxt = S_DONE;
      S_Q_CLR:   if (cnt_r == CW'(MAX_VERTICES - 1)) state_nxt = S_Q_POP;
      S_Q_POP:   state_nxt = (cnt_r < tail_r && cnt_r < CW'(MAX_VERTICES)) ? S_Q_HEAD
                           : S_Q_DST;
      S_Q_HEAD:  state_nxt = S_Q_FETCH;
      S_Q_FETCH: state_nxt = S_Q_LINK;
      S_Q_LINK:  state_nxt = (link_r != '0 && link_r <= LW'(2*MAX_EDGES)) ? S_Q_EDGE
                           : S_Q_POP;
      S_Q_EDGE:  state_nxt = S_Q_VIS;
      S_Q_VIS:   state_nxt = S_Q_LINK;
      S_Q_DST:   state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memories: at most one write and one read per memory per cycle
  always_ff @(posedge clk) begin
    // head store: clear sweep, add reads and writes, query reads
    if (state_r == S_CLR) mem_first[cnt_r[VW-1:0]] <= '0;
    else if (state_r == S_ADD_RD) mem_first[va_r] <= LW'({nedge_r[EW-1:0], 1'b0}) + 1'b1;
    else if (state_r == S_ADD_WR) mem_first[vb_r] <= LW'({nedge_r[EW-1:0], 1'b1}) + 1'b1;
    // first_rd during S_ADD_RD holds head of va read at acceptance
    if (state_r == S_IDLE) first_rd <= mem_first[in_vertex_a];
    else if (state_r == S_ADD_RD) first_rd <= mem_first[vb_r];
    else first_rd <= mem_first[q_rd];

    if (state_r == S_ADD_RD) mem_next[{nedge_r[EW-1:0], 1'b0}] <= first_rd;
    else if (state_r == S_ADD_WR) mem_next[{nedge_r[EW-1:0], 1'b1}] <= fa_sel(va_r, vb_r);
    next_rd <= mem_next[h];

    if (state_r == S_ADD_WR) begin
      mem_ea[nedge_r[EW-1:0]] <= va_r;
      mem_eb[nedge_r[EW-1:0]] <= vb_r;
      mem_ew[nedge_r[EW-1:0]] <= w_r;
    end
    ea_rd <= mem_ea[e];
    eb_rd <= mem_eb[e];
    ew_rd <= mem_ew[e];

    if (state_r == S_Q_CLR) mem_vis[cnt_r[VW-1:0]] <= (cnt_r[VW-1:0] == va_r);
    else if (state_r == S_Q_VIS && visit_ok) mem_vis[other_sel] <= 1'b1;
    vis_rd <= mem_vis[(state_r == S_Q_EDGE) ? other_sel : vb_r];

    if (state_r == S_Q_CLR) mem_q[0] <= va_r;
    else if (state_r == S_Q_VIS && visit_ok) mem_q[tail_r[VW-1:0]] <= other_r;
    q_rd <= mem_q[cnt_r[VW-1:0]];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcount_r <= 9'd256;
      nedge_r <= '0;
      cnt_r <= '0;
      ovld_r <= 1'b0;
      init_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vcount_r <= cfg_vertex_count;
      if (ovld_r && out_ready) ovld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_valid && in_ready) begin
            va_r <= in_vertex_a;
            vb_r <= in_vertex_b;
            w_r <= in_width_value;
            oreach_r <= 1'b0;
            ostat_r <= ST_OK;
            if (in_action == ACT_CLEAR) nedge_r <= '0;
            if ((in_action == ACT_ADD || in_action == ACT_QUERY) && range_bad)
              ostat_r <= ST_RANGE;
            else if (in_action == ACT_ADD && nedge_r >= NW'(MAX_EDGES))
              ostat_r <= ST_FULL;
          end
        end
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(MAX_VERTICES - 1)) init_r <= 1'b0;
        end
        S_ADD_RD: fa_r <= LW'({nedge_r[EW-1:0], 1'b0}) + 1'b1;
        S_ADD_WR: nedge_r <= nedge_r + 1'b1;
        S_Q_CLR: begin
          tail_r <= CW'(1);
          cnt_r <= (cnt_r == CW'(MAX_VERTICES - 1)) ? '0 : cnt_r + 1'b1;
        end
        S_Q_POP: cnt_r <= cnt_r + 1'b1;   // q_rd valid in S_Q_HEAD
        S_Q_FETCH: link_r <= first_rd;    // head read issued in S_Q_HEAD
        S_Q_EDGE: begin
          other_r <= other_sel;
          wide_r <= link_ok && (ew_rd >= w_r);
        end
        S_Q_VIS: begin
          if (visit_ok) tail_r <= tail_r + 1'b1;
          link_r <= next_rd;
        end
        S_Q_DST: oreach_r <= vis_rd;
        S_DONE: ovld_r <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/wlr_checker.sv =====
module wlr_checker
  import wlr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_reachable,
  input logic [1:0] out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_reachable))
    else $error("result word changed while stalled");

  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken with result pending");

  a_reach_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reachable |-> out_status == ST_OK)
    else $error("reachable with error status");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

endmodule

bind width_limited_reachability wlr_checker u_wlr_checker (.*);

// ===== tb/sv/tb_width_limited_reachability.sv =====
`timescale 1ns / 100ps

module tb_width_limited_reachability;
  import wlr_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = '0;
  logic [7:0]            in_vertex_a = '0;
  logic [7:0]            in_vertex_b = '0;
  logic [WIDTH_BITS-1:0] in_width_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_reachable;
  logic [1:0]            out_status;
  logic                  cfg_we = 1'b0;
  logic [8:0]            cfg_vertex_count = 9'd256;

  width_limited_reachability u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_width_value(in_width_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reachable(out_reachable), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_vertex_count(cfg_vertex_count)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic    reach;
    status_t status;
  } answer_t;

  typedef struct {
    action_t         act;
    logic [7:0]      va;
    logic [7:0]      vb;
    logic [15:0]     w;
    logic            fixed;   // expected answer typed in
    answer_t         ans;
  } row_t;

  // graph mirror
  int unsigned     vcount;
  logic [7:0]      g_a [MAX_EDGES];
  logic [7:0]      g_b [MAX_EDGES];
  logic [15:0]     g_w [MAX_EDGES];
  int unsigned     g_n;
  answer_t         answer_q[$];
  int              mismatches = 0;
  int              words_out = 0;

  function automatic logic bfs_reach(int unsigned src, int unsigned dst,
                                     logic [15:0] truck);
    logic seen [MAX_VERTICES];
    int   fifo [$];
    int   v;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[src] = 1'b1;
    fifo.push_back(src);
    while (fifo.size() > 0) begin
      v = fifo.pop_front();
      for (int e = 0; e < g_n; e++) begin
        if (g_w[e] >= truck) begin
          if (g_a[e] == v && !seen[g_b[e]]) begin
            seen[g_b[e]] = 1'b1; fifo.push_back(g_b[e]);
          end
          if (g_b[e] == v && !seen[g_a[e]]) begin
            seen[g_a[e]] = 1'b1; fifo.push_back(g_a[e]);
          end
        end
      end
    end
    return seen[dst];
  endfunction

  function automatic answer_t apply_word(action_t act, logic [7:0] va, logic [7:0] vb,
                                         logic [15:0] w);
    answer_t     r;
    int unsigned lim;
    r.reach = 1'b0;
    r.status = ST_OK;
    lim = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
    if (act == ACT_CLEAR) begin
      g_n = 0;
    end else if (act == ACT_ADD || act == ACT_QUERY) begin
      if (va >= lim || vb >= lim) begin
        r.status = ST_RANGE;
      end else if (act == ACT_ADD) begin
        if (g_n >= MAX_EDGES) begin
          r.status = ST_FULL;
        end else begin
          g_a[g_n] = va; g_b[g_n] = vb; g_w[g_n] = w;
          g_n++;
        end
      end else begin
        r.reach = bfs_reach(va, vb, w);
      end
    end
    return r;
  endfunction

  // an idle gap between words so valid drops before the next one
  task automatic idle_gap(int unsigned pct);
    int n;
    n = 1;
    if ($urandom_range(99) < pct)
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(action_t act, logic [7:0] va, logic [7:0] vb, logic [15:0] w,
                           logic fixed, answer_t typed);
    answer_t p;
    idle_gap(35);
    p = apply_word(act, va, vb, w);
    if (fixed && p !== typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with prediction: typed %p predicted %p", typed, p);
    end
    answer_q.push_back(p);
    in_valid <= 1'b1;
    in_action <= act;
    in_vertex_a <= va;
    in_vertex_b <= vb;
    in_width_value <= w;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
  endtask

  task automatic set_vertex_count(logic [8:0] n);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_vertex_count <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = n;
  endtask

  // sink side
  initial begin
    answer_t exp;
    wait (rst_n);
    forever begin
      if ($urandom_range(19) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(40, 5)) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) < 70) || ($urandom_range(3) == 0 && 1'b1);
      @(posedge clk);
      if (out_valid && out_ready) begin
        words_out++;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word");
        end else begin
          exp = answer_q.pop_front();
          if (out_reachable !== exp.reach || out_status !== exp.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected reach %0b status %0d, got reach %0b status %0d",
                       exp.reach, exp.status, out_reachable, out_status);
          end
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  localparam answer_t A_OK    = '{reach: 1'b0, status: ST_OK};
  localparam answer_t A_YES   = '{reach: 1'b1, status: ST_OK};
  localparam answer_t A_RANGE = '{reach: 1'b0, status: ST_RANGE};

  row_t dir_rows[$];

  initial begin
    action_t     act;
    logic [7:0]  va, vb;
    logic [15:0] w;
    int          pick, base;

    vcount = 256;
    g_n = 0;
    dir_rows = '{
      '{ACT_QUERY, 8'd0,   8'd0,   16'hFFFF, 1'b1, A_YES},
      '{ACT_QUERY, 8'd0,   8'd255, 16'h0000, 1'b1, A_OK},
      '{ACT_ADD,   8'd0,   8'd255, 16'hFFFF, 1'b1, A_OK},
      '{ACT_QUERY, 8'd255, 8'd0,   16'hFFFF, 1'b1, A_YES},
      '{ACT_ADD,   8'd255, 8'd128, 16'h0000, 1'b1, A_OK},
      '{ACT_QUERY, 8'd0,   8'd128, 16'h0001, 1'b1, A_OK},
      '{ACT_QUERY, 8'd0,   8'd128, 16'h0000, 1'b1, A_YES},
      '{ACT_ADD,   8'd7,   8'd7,   16'h5A5A, 1'b1, A_OK},   // self-loop
      '{ACT_QUERY, 8'd7,   8'd8,   16'h0000, 1'b1, A_OK},
      '{ACT_ADD,   8'd8,   8'd9,   16'h8000, 1'b0, A_OK},
      '{ACT_ADD,   8'd9,   8'd7,   16'h7FFF, 1'b0, A_OK},
      '{ACT_QUERY, 8'd8,   8'd7,   16'h7FFF, 1'b0, A_OK},
      '{ACT_QUERY, 8'd8,   8'd7,   16'h8000, 1'b0, A_OK},
      '{ACT_NONE,  8'hAA,  8'h55,  16'hFFFF, 1'b1, A_OK},
      '{ACT_CLEAR, 8'd0,   8'd0,   16'h0000, 1'b1, A_OK},
      '{ACT_QUERY, 8'd0,   8'd255, 16'h0000, 1'b1, A_OK}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].act, dir_rows[i].va, dir_rows[i].vb, dir_rows[i].w,
                dir_rows[i].fixed, dir_rows[i].ans);

    // lowered count: range errors and an add inside the range
    set_vertex_count(9'd10);
    send_word(ACT_ADD, 8'd2, 8'd200, 16'd1, 1'b1, A_RANGE);
    send_word(ACT_QUERY, 8'd10, 8'd0, 16'd1, 1'b1, A_RANGE);
    send_word(ACT_ADD, 8'd9, 8'd3, 16'd50, 1'b1, A_OK);
    set_vertex_count(9'd0);
    send_word(ACT_QUERY, 8'd0, 8'd0, 16'd0, 1'b1, A_RANGE);
    set_vertex_count(9'd511);
    send_word(ACT_QUERY, 8'd255, 8'd3, 16'd0, 1'b0, A_OK);
    set_vertex_count(9'd1);
    send_word(ACT_QUERY, 8'd0, 8'd0, 16'd9, 1'b1, A_YES);

    // random part in phases of vertex counts, mostly small graphs
    for (int ph = 0; ph < 6; ph++) begin
      pick = (ph == 5) ? 256 : $urandom_range(24, 2);
      set_vertex_count(pick[8:0]);
      send_word(ACT_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, A_OK);
      for (int k = 0; k < 40; k++) begin
        base = $urandom_range(99);
        act = (base < 45) ? ACT_ADD : (base < 90) ? ACT_QUERY :
              (base < 95) ? ACT_NONE : ACT_CLEAR;
        if ($urandom_range(9) == 0) begin
          va = 8'($urandom); vb = 8'($urandom);
        end else begin
          va = 8'($urandom_range(pick - 1)); vb = 8'($urandom_range(pick - 1));
        end
        w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8) << 13);
        send_word(act, va, vb, w, 1'b0, A_OK);
      end
    end

    while (answer_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
